/* rtl/averaged_deadband_servo_map_unit_defines.svh */
// Assertion macros for the averaged deadband servo map unit.
`ifndef AVERAGED_DEADBAND_SERVO_MAP_UNIT_DEFINES_SVH
`define AVERAGED_DEADBAND_SERVO_MAP_UNIT_DEFINES_SVH

// Condition holds in the same cycle as the trigger.
`define ADSM_ASSERT_SAME(name, trig, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |-> (prop)) \
        else $error("adsm assertion failed");

// Condition holds in the cycle after the trigger.
`define ADSM_ASSERT_NEXT(name, trig, prop) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) (trig) |=> (prop)) \
        else $error("adsm assertion failed");

`endif

/* rtl/adsm_pkg.sv */
// Shared widths, reset values, register indexes and types of the servo map unit.
`timescale 1ns / 1ps

package adsm_pkg;

    localparam int SAMPLE_W  = 10;
    localparam int COUNT_W   = 10;
    localparam int CFG_W     = 14;
    localparam int LEVEL_W   = 10;
    localparam int PULSE_W   = 11;
    localparam int SUM_W     = SAMPLE_W + COUNT_W;
    localparam int ACC_W     = SAMPLE_W + PULSE_W + 4;
    localparam int STEP_W    = $clog2(SAMPLE_W + 1);
    localparam int DB_W      = (SAMPLE_W > COUNT_W) ? SAMPLE_W : COUNT_W;
    localparam int S_TDATA_W = ((SAMPLE_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((PULSE_W + LEVEL_W + 7) / 8) * 8;

    localparam logic [COUNT_W-1:0] WINDOW_RESET    = COUNT_W'(500);
    localparam logic [COUNT_W-1:0] DEADBAND_RESET  = COUNT_W'(1);
    localparam logic [CFG_W-1:0]   PULSE_MIN_RESET = CFG_W'(1481);
    localparam logic [CFG_W-1:0]   PULSE_SPAN_RESET = CFG_W'(7407);

    // half an output LSB, for round to nearest
    localparam logic [ACC_W-1:0] ROUND_BIAS = ACC_W'(1) << (SAMPLE_W + 3);

    typedef enum logic [1:0] {
        CFG_WINDOW_COUNT = 2'd0,
        CFG_DEADBAND     = 2'd1,
        CFG_PULSE_MIN    = 2'd2,
        CFG_PULSE_SPAN   = 2'd3
    } cfg_index_t;

    typedef struct packed {
        logic busy;
        logic done;
    } unit_status_t;

endpackage

/* rtl/adsm_divider.sv */
// Bit-serial restoring divider: window sum over sample count, one quotient bit a cycle.
`timescale 1ns / 1ps

module adsm_divider (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [adsm_pkg::SUM_W-1:0]    dividend,
    input  logic [adsm_pkg::COUNT_W-1:0]  divisor,
    output logic [adsm_pkg::SAMPLE_W-1:0] quotient,
    output adsm_pkg::unit_status_t        status
);
    import adsm_pkg::*;

    logic [COUNT_W-1:0]  rem_reg, rem_next;
    logic [SAMPLE_W-1:0] lo_reg, lo_next;
    logic [COUNT_W-1:0]  dvs_reg, dvs_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    logic [COUNT_W:0]    trial;
    logic [COUNT_W:0]    trial_sub;
    logic                fits;

    assign trial     = {rem_reg, lo_reg[SAMPLE_W-1]};
    assign trial_sub = trial - {1'b0, dvs_reg};
    assign fits      = trial >= {1'b0, dvs_reg};

    always_comb begin
        rem_next  = rem_reg;
        lo_next   = lo_reg;
        dvs_next  = dvs_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start) begin
            // quotient fits SAMPLE_W bits, so the upper sum bits are below the divisor
            rem_next  = dividend[SUM_W-1:SAMPLE_W];
            lo_next   = dividend[SAMPLE_W-1:0];
            dvs_next  = divisor;
            step_next = '0;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            rem_next  = fits ? trial_sub[COUNT_W-1:0] : trial[COUNT_W-1:0];
            lo_next   = {lo_reg[SAMPLE_W-2:0], fits};
            step_next = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        lo_reg  <= lo_next;
        dvs_reg <= dvs_next;
    end

    assign quotient    = lo_reg;
    assign status.busy = busy_reg;
    assign status.done = done_reg;

endmodule

/* rtl/adsm_mapper.sv */
// Shift-add multiplier mapping the held level to a rounded compare value, one level bit a cycle.
`timescale 1ns / 1ps

module adsm_mapper (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic [adsm_pkg::SAMPLE_W-1:0] level,
    input  logic [adsm_pkg::CFG_W-1:0]    pulse_min_q4,
    input  logic [adsm_pkg::CFG_W-1:0]    pulse_span_q4,
    output logic [adsm_pkg::PULSE_W-1:0]  pulse_compare,
    output adsm_pkg::unit_status_t        status
);
    import adsm_pkg::*;

    logic [ACC_W-1:0]    acc_reg, acc_next;
    logic [ACC_W-1:0]    mcand_reg, mcand_next;
    logic [SAMPLE_W-1:0] mplier_reg, mplier_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic                busy_reg, busy_next;
    logic                done_reg, done_next;

    always_comb begin
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        step_next   = step_reg;
        busy_next   = busy_reg;
        done_next   = 1'b0;
        if (start) begin
            acc_next    = ACC_W'({pulse_min_q4, {SAMPLE_W{1'b0}}}) + ROUND_BIAS;
            mcand_next  = ACC_W'(pulse_span_q4);
            mplier_next = level;
            step_next   = '0;
            busy_next   = 1'b1;
        end else if (busy_reg) begin
            if (mplier_reg[0]) begin
                acc_next = acc_reg + mcand_reg;
            end
            mcand_next  = {mcand_reg[ACC_W-2:0], 1'b0};
            mplier_next = {1'b0, mplier_reg[SAMPLE_W-1:1]};
            step_next   = step_reg + STEP_W'(1);
            if (step_reg == STEP_W'(SAMPLE_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            step_reg <= step_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
    end

    // full-scale sum stays below 2^ACC_W, so the top bits never exceed the max code
    assign pulse_compare = acc_reg[ACC_W-1:SAMPLE_W+4];
    assign status.busy   = busy_reg;
    assign status.done   = done_reg;

endmodule

/* rtl/averaged_deadband_servo_map_unit.sv */
// Top level: window accumulator, deadband hold, serial divide and serial compare mapping.
//
//  channel   direction  handshake          payload
//  s_        in         s_tvalid/s_tready  s_tdata: sample
//  m_        out        m_tvalid/m_tready  m_tdata: pulse_compare, level; m_tuser: changed
//  cfg_      in         cfg_wen            cfg_index, cfg_wdata
//
// A sample that does not close a window is added to the sum and count while the
// unit stays idle and ready. A closing sample holds s_tready low through the
// SAMPLE_W divider steps and their done flag, the deadband step, the SAMPLE_W
// multiplier steps and their done flag, and the output load; both units are serial.
// Reset is synchronous, active low; configuration returns to its defaults.
// A stalled result holds the output register; non-closing samples are still
// taken, and a closing one waits in the output-load step until the register frees.
`timescale 1ns / 1ps

`include "averaged_deadband_servo_map_unit_defines.svh"

module averaged_deadband_servo_map_unit (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [adsm_pkg::S_TDATA_W-1:0] s_tdata,   // sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [adsm_pkg::M_TDATA_W-1:0] m_tdata,   // pulse_compare, level
    output logic                           m_tuser,   // changed
    input  logic                           cfg_wen,
    input  adsm_pkg::cfg_index_t           cfg_index,
    input  logic [adsm_pkg::CFG_W-1:0]     cfg_wdata
);
    import adsm_pkg::*;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_DIV  = 5'b00010,
        ST_DEAD = 5'b00100,
        ST_MUL  = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  window_reg, window_next;
    logic [COUNT_W-1:0]  deadband_reg, deadband_next;
    logic [CFG_W-1:0]    pmin_reg, pmin_next;
    logic [CFG_W-1:0]    pspan_reg, pspan_next;
    logic [SUM_W-1:0]    sum_reg, sum_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [SAMPLE_W-1:0] held_reg, held_next;
    logic                changed_reg, changed_next;
    logic                m_valid_reg, m_valid_next;
    logic [PULSE_W-1:0]  m_pulse_reg, m_pulse_next;
    logic [LEVEL_W-1:0]  m_level_reg, m_level_next;
    logic                m_changed_reg, m_changed_next;

    logic                in_fire;
    logic [SUM_W-1:0]    sum_inc;
    logic [COUNT_W-1:0]  count_inc;
    logic                closing;
    logic                div_start;
    logic                map_start;
    logic [SAMPLE_W-1:0] avg;
    logic [SAMPLE_W-1:0] diff;
    logic [PULSE_W-1:0]  pulse_compare;
    logic                out_free;
    unit_status_t        div_status;
    unit_status_t        map_status;

    assign s_tready  = (state_reg == ST_IDLE);
    assign in_fire   = s_tvalid && s_tready;
    assign sum_inc   = sum_reg + SUM_W'(s_tdata[SAMPLE_W-1:0]);
    assign count_inc = count_reg + COUNT_W'(1);
    assign closing   = (count_inc == '0) || (count_inc >= window_reg);
    assign div_start = in_fire && closing;
    assign map_start = (state_reg == ST_DEAD);
    assign diff      = (avg > held_reg) ? (avg - held_reg) : (held_reg - avg);
    assign out_free  = !m_valid_reg || m_tready;

    adsm_divider u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_inc),
        .divisor  (count_inc),
        .quotient (avg),
        .status   (div_status)
    );

    adsm_mapper u_mapper (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .start         (map_start),
        .level         (held_next),
        .pulse_min_q4  (pmin_reg),
        .pulse_span_q4 (pspan_reg),
        .pulse_compare (pulse_compare),
        .status        (map_status)
    );

    always_comb begin
        window_next   = window_reg;
        deadband_next = deadband_reg;
        pmin_next     = pmin_reg;
        pspan_next    = pspan_reg;
        if (cfg_wen) begin
            case (cfg_index)
                CFG_WINDOW_COUNT: window_next   = cfg_wdata[COUNT_W-1:0];
                CFG_DEADBAND:     deadband_next = cfg_wdata[COUNT_W-1:0];
                CFG_PULSE_MIN:    pmin_next     = cfg_wdata;
                CFG_PULSE_SPAN:   pspan_next    = cfg_wdata;
                default:          ;
            endcase
        end
    end

    always_comb begin
        state_next     = state_reg;
        sum_next       = sum_reg;
        count_next     = count_reg;
        held_next      = held_reg;
        changed_next   = changed_reg;
        m_valid_next   = m_valid_reg && !m_tready;
        m_pulse_next   = m_pulse_reg;
        m_level_next   = m_level_reg;
        m_changed_next = m_changed_reg;
        case (state_reg)
            ST_IDLE: begin
                if (in_fire) begin
                    if (closing) begin
                        sum_next   = '0;
                        count_next = '0;
                        state_next = ST_DIV;
                    end else begin
                        sum_next   = sum_inc;
                        count_next = count_inc;
                    end
                end
            end
            ST_DIV: begin
                if (div_status.done) begin
                    state_next = ST_DEAD;
                end
            end
            ST_DEAD: begin
                changed_next = DB_W'(diff) > DB_W'(deadband_reg);
                if (changed_next) begin
                    held_next = avg;
                end
                state_next = ST_MUL;
            end
            ST_MUL: begin
                if (map_status.done) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_pulse_next   = pulse_compare;
                    m_level_next   = LEVEL_W'(held_reg);
                    m_changed_next = changed_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            window_reg   <= WINDOW_RESET;
            deadband_reg <= DEADBAND_RESET;
            pmin_reg     <= PULSE_MIN_RESET;
            pspan_reg    <= PULSE_SPAN_RESET;
            sum_reg      <= '0;
            count_reg    <= '0;
            held_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            window_reg   <= window_next;
            deadband_reg <= deadband_next;
            pmin_reg     <= pmin_next;
            pspan_reg    <= pspan_next;
            sum_reg      <= sum_next;
            count_reg    <= count_next;
            held_reg     <= held_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        changed_reg   <= changed_next;
        m_pulse_reg   <= m_pulse_next;
        m_level_reg   <= m_level_next;
        m_changed_reg <= m_changed_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = M_TDATA_W'({m_level_reg, m_pulse_reg});
    assign m_tuser  = m_changed_reg;

    `ADSM_ASSERT_SAME(a_idle_units_quiet, s_tready, !div_status.busy && !map_status.busy)
    `ADSM_ASSERT_NEXT(a_div_done_to_dead, div_status.done, state_reg == ST_DEAD)
    `ADSM_ASSERT_NEXT(a_hold_kept, (state_reg == ST_DEAD) && !changed_next, $stable(held_reg))
    `ADSM_ASSERT_NEXT(a_map_done_to_out, map_status.done, state_reg == ST_OUT)

endmodule
